// ===== hw/rtl/twsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-wheel speed controller package
// Shared widths, constants, datapath commands and register indexes.
// ----------------------------------------------------------------------------
package twsc_pkg;

   localparam int SpeedW  = 24;
   localparam int AdcW    = 12;
   localparam int GainW   = 16;
   localparam int LimitW  = 23;
   localparam int DutyW   = 10;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 23;
   localparam int ReqDataW = 120;
   localparam int RspDataW = 24;

   localparam logic [DutyW-1:0] DUTY_MAX = 10'd1023;

   localparam logic signed [GainW-1:0]  INTEGRAL_GAIN_RST = -16'sd6476;
   localparam logic signed [GainW-1:0]  SPEED_GAIN_RST    = 16'sd1819;
   localparam logic signed [GainW-1:0]  CURRENT_GAIN_RST  = 16'sd271;
   localparam logic [LimitW-1:0]        INTEGRAL_LIMIT_RST = 23'd65536;
   localparam logic [AdcW-1:0]          ZERO_CURRENT_RST  = 12'd0;

   localparam logic signed [32:0] INT32_MAX_33 = 33'sd2147483647;
   localparam logic signed [32:0] INT32_MIN_33 = -33'sd2147483648;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_INTEGRAL_GAIN  = 3'd0,
      CSR_SPEED_GAIN     = 3'd1,
      CSR_CURRENT_GAIN   = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_ZERO_CURRENT   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_LOAD  = 4'd1,
      OP_ERR   = 4'd2,
      OP_SCALE = 4'd3,
      OP_INTEG = 4'd4,
      OP_CLAMP = 4'd5,
      OP_MUL_I = 4'd6,
      OP_MUL_S = 4'd7,
      OP_MUL_C = 4'd8,
      OP_ACC   = 4'd9,
      OP_FINAL = 4'd10,
      OP_DUTY  = 4'd11,
      OP_OUT   = 4'd12
   } op_type;

   typedef struct packed {
      op_type op;
      logic   wheel;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/twsc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-wheel speed controller sequencer
// Steps both wheels through the datapath and runs the word handshakes.
// ----------------------------------------------------------------------------
module twsc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output twsc_pkg::cmd_type      cmd
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_ERR   = 12'b000000000010,
      S_SCALE = 12'b000000000100,
      S_INTEG = 12'b000000001000,
      S_CLAMP = 12'b000000010000,
      S_MUL_I = 12'b000000100000,
      S_MUL_S = 12'b000001000000,
      S_MUL_C = 12'b000010000000,
      S_ACC   = 12'b000100000000,
      S_FINAL = 12'b001000000000,
      S_DUTY  = 12'b010000000000,
      S_DONE  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      wheel_ff, wheel_in;
   logic      rsp_valid_ff, rsp_valid_in;
   twsc_pkg::op_type op;

   always_comb begin
      state_in = state_ff;
      wheel_in = wheel_ff;
      op       = twsc_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op       = twsc_pkg::OP_LOAD;
               wheel_in = 1'b0;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            op       = twsc_pkg::OP_ERR;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            op       = twsc_pkg::OP_SCALE;
            state_in = S_INTEG;
         end
         S_INTEG: begin
            op       = twsc_pkg::OP_INTEG;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            op       = twsc_pkg::OP_CLAMP;
            state_in = S_MUL_I;
         end
         S_MUL_I: begin
            op       = twsc_pkg::OP_MUL_I;
            state_in = S_MUL_S;
         end
         S_MUL_S: begin
            op       = twsc_pkg::OP_MUL_S;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            op       = twsc_pkg::OP_MUL_C;
            state_in = S_ACC;
         end
         S_ACC: begin
            op       = twsc_pkg::OP_ACC;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            op       = twsc_pkg::OP_FINAL;
            state_in = S_DUTY;
         end
         S_DUTY: begin
            op = twsc_pkg::OP_DUTY;
            if (wheel_ff) begin
               state_in = S_DONE;
            end else begin
               wheel_in = 1'b1;
               state_in = S_ERR;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               op       = twsc_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (op == twsc_pkg::OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wheel_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign cmd        = '{op: op, wheel: wheel_ff};

endmodule
`default_nettype wire

// ===== hw/rtl/twsc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-wheel speed controller datapath
// Per-wheel integrator, anti-windup clamp, shared gain multiplier and duty
// shaping, plus the configuration registers and the result register.
// ----------------------------------------------------------------------------
module twsc_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire twsc_pkg::cmd_type                    cmd,
   input  wire logic [twsc_pkg::ReqDataW-1:0]        req_tdata,
   output logic [twsc_pkg::RspDataW-1:0]             rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [twsc_pkg::CsrAddrW-1:0]        csr_addr,
   input  wire logic [twsc_pkg::CsrDataW-1:0]        csr_wdata
);

   // Configuration registers.
   logic signed [15:0] ki_ff, ks_ff, kc_ff;
   logic [22:0]        limit_ff;
   logic [11:0]        offset_ff;

   // Latched input word and per-wheel state.
   logic [119:0]       word_ff;
   logic signed [31:0] integ_ff [2];
   logic signed [31:0] exc_ff [2];

   // Working registers.
   logic               zero_ff;
   logic signed [36:0] err_ff;
   logic signed [17:0] cur_ff;
   logic signed [29:0] t_ff;
   logic signed [31:0] x_ff;
   logic signed [23:0] xc_ff;
   logic signed [39:0] prod_ff;
   logic signed [31:0] acc_ff;
   logic signed [26:0] v_ff;
   logic [9:0]         duty_ff [2];
   logic               rev_ff [2];
   logic [23:0]        rsp_ff;

   logic signed [23:0] ref_sel, meas_sel;
   logic [11:0]        adc_sel;
   logic signed [31:0] integ_sel, exc_sel;
   logic signed [24:0] diff;
   logic signed [35:0] exc36, ten_exc;
   logic signed [36:0] err_w;
   logic signed [12:0] adc_diff;
   logic signed [17:0] cur_w;
   logic signed [44:0] e45, p210;
   logic signed [29:0] t_w;
   logic signed [37:0] xs;
   logic signed [32:0] xq, x33, lim33;
   logic signed [31:0] x_w;
   logic signed [23:0] xc_w;
   logic signed [31:0] ex_w;
   logic signed [15:0] gain_sel;
   logic signed [23:0] opnd_sel;
   logic signed [39:0] prod_w;
   logic signed [28:0] pterm;
   logic signed [38:0] a39, p73;
   logic signed [26:0] v_w, mag;
   logic [9:0]         duty_w;

   always_comb begin
      if (cmd.wheel) begin
         ref_sel  = $signed(word_ff[47:24]);
         meas_sel = $signed(word_ff[95:72]);
         adc_sel  = word_ff[119:108];
      end else begin
         ref_sel  = $signed(word_ff[23:0]);
         meas_sel = $signed(word_ff[71:48]);
         adc_sel  = word_ff[107:96];
      end
   end

   assign integ_sel = integ_ff[cmd.wheel];
   assign exc_sel   = exc_ff[cmd.wheel];

   // Speed error less ten times the windup excess, and the motor current.
   assign diff     = 25'(ref_sel) - 25'(meas_sel);
   assign exc36    = 36'(exc_sel);
   assign ten_exc  = (exc36 <<< 3) + (exc36 <<< 1);
   assign err_w    = 37'(diff) - 37'(ten_exc);
   assign adc_diff = $signed({1'b0, adc_sel}) - $signed({1'b0, offset_ff});
   assign cur_w    = (18'(adc_diff) <<< 4) + 18'(adc_diff);

   // Integrator input: 210 * err, arithmetic shift right by 15.
   assign e45  = 45'(err_ff);
   assign p210 = (e45 <<< 8) - (e45 <<< 5) - (e45 <<< 4) + (e45 <<< 1);
   assign t_w  = 30'(p210 >>> 15);

   // Backward Euler update with saturation to 32 bits.
   assign xs = (38'(integ_sel) <<< 5) + 38'(t_ff);
   assign xq = 33'(xs >>> 5);
   always_comb begin
      if (zero_ff) begin
         x_w = 32'sd0;
      end else if (xq > twsc_pkg::INT32_MAX_33) begin
         x_w = 32'(twsc_pkg::INT32_MAX_33);
      end else if (xq < twsc_pkg::INT32_MIN_33) begin
         x_w = 32'(twsc_pkg::INT32_MIN_33);
      end else begin
         x_w = 32'(xq);
      end
   end

   // Symmetric clamp; the part beyond the limit is the excess.
   assign x33   = 33'(x_ff);
   assign lim33 = $signed({10'd0, limit_ff});
   always_comb begin
      if (x33 >= lim33) begin
         xc_w = 24'(lim33);
         ex_w = 32'(x33 - lim33);
      end else if (x33 <= -lim33) begin
         xc_w = 24'(-lim33);
         ex_w = 32'(x33 + lim33);
      end else begin
         xc_w = 24'(x33);
         ex_w = 32'sd0;
      end
   end

   // Shared gain multiplier.
   always_comb begin
      case (cmd.op)
         twsc_pkg::OP_MUL_S: begin
            gain_sel = ks_ff;
            opnd_sel = meas_sel;
         end
         twsc_pkg::OP_MUL_C: begin
            gain_sel = kc_ff;
            opnd_sel = 24'(cur_ff);
         end
         default: begin
            gain_sel = ki_ff;
            opnd_sel = xc_ff;
         end
      endcase
   end
   assign prod_w = 40'(gain_sel) * 40'(opnd_sel);
   assign pterm  = 29'(prod_ff >>> 11);

   // Output scaling by 73 >> 12, then direction and saturated magnitude.
   assign a39 = 39'(acc_ff);
   assign p73 = (a39 <<< 6) + (a39 <<< 3) + a39;
   assign v_w = 27'(p73 >>> 12);
   assign mag = v_ff[26] ? -v_ff : v_ff;
   assign duty_w = (mag > 27'(twsc_pkg::DUTY_MAX)) ? twsc_pkg::DUTY_MAX : mag[9:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ki_ff       <= twsc_pkg::INTEGRAL_GAIN_RST;
         ks_ff       <= twsc_pkg::SPEED_GAIN_RST;
         kc_ff       <= twsc_pkg::CURRENT_GAIN_RST;
         limit_ff    <= twsc_pkg::INTEGRAL_LIMIT_RST;
         offset_ff   <= twsc_pkg::ZERO_CURRENT_RST;
         integ_ff[0] <= 32'sd0;
         integ_ff[1] <= 32'sd0;
         exc_ff[0]   <= 32'sd0;
         exc_ff[1]   <= 32'sd0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               twsc_pkg::CSR_INTEGRAL_GAIN:  ki_ff     <= $signed(csr_wdata[15:0]);
               twsc_pkg::CSR_SPEED_GAIN:     ks_ff     <= $signed(csr_wdata[15:0]);
               twsc_pkg::CSR_CURRENT_GAIN:   kc_ff     <= $signed(csr_wdata[15:0]);
               twsc_pkg::CSR_INTEGRAL_LIMIT: limit_ff  <= csr_wdata;
               twsc_pkg::CSR_ZERO_CURRENT:   offset_ff <= csr_wdata[11:0];
               default: begin
               end
            endcase
         end
         if (cmd.op == twsc_pkg::OP_INTEG) begin
            integ_ff[cmd.wheel] <= x_w;
         end
         if (cmd.op == twsc_pkg::OP_CLAMP) begin
            exc_ff[cmd.wheel] <= ex_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         twsc_pkg::OP_LOAD: begin
            word_ff <= req_tdata;
         end
         twsc_pkg::OP_ERR: begin
            err_ff  <= err_w;
            cur_ff  <= cur_w;
            zero_ff <= (ref_sel == 24'sd0);
         end
         twsc_pkg::OP_SCALE: begin
            t_ff <= t_w;
         end
         twsc_pkg::OP_INTEG: begin
            x_ff <= x_w;
         end
         twsc_pkg::OP_CLAMP: begin
            xc_ff <= xc_w;
         end
         twsc_pkg::OP_MUL_I: begin
            prod_ff <= prod_w;
         end
         twsc_pkg::OP_MUL_S: begin
            acc_ff  <= -32'(pterm);
            prod_ff <= prod_w;
         end
         twsc_pkg::OP_MUL_C: begin
            acc_ff  <= acc_ff - 32'(pterm);
            prod_ff <= prod_w;
         end
         twsc_pkg::OP_ACC: begin
            acc_ff <= acc_ff - 32'(pterm);
         end
         twsc_pkg::OP_FINAL: begin
            v_ff <= zero_ff ? 27'sd0 : v_w;
         end
         twsc_pkg::OP_DUTY: begin
            duty_ff[cmd.wheel] <= duty_w;
            rev_ff[cmd.wheel]  <= v_ff[26];
         end
         twsc_pkg::OP_OUT: begin
            rsp_ff <= {2'b00, rev_ff[1], duty_ff[1], rev_ff[0], duty_ff[0]};
         end
         default: begin
         end
      endcase
   end

   assign rsp_tdata = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/two_wheel_state_feedback_speed_ctrl_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Two-wheel state-feedback speed controller
// Integral state feedback with anti-windup for a left and a right wheel.
// ----------------------------------------------------------------------------
// One input word is one control tick for both wheels. The block takes a word
// when idle and returns one result word; it takes no new word before it is
// through with the last one. The sequencer runs each wheel through ten steps
// of one datapath (error, integrator scaling, integrator update, clamp, three
// passes of the shared 16x24 gain multiplier with accumulation, output
// scaling and duty shaping), plus one load and one output step. A finished
// result waits in the output register while the next word is accepted; the
// next output step waits until it is taken. Configuration writes are taken
// in any cycle and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module two_wheel_state_feedback_speed_ctrl_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // ref_right[23:0], ref_left[47:24], meas_right[71:48], meas_left[95:72],
   // adc_right[107:96], adc_left[119:108]
   input  wire logic [twsc_pkg::ReqDataW-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // duty_right[9:0], reverse_right[10], duty_left[20:11], reverse_left[21],
   // zero fill [23:22]
   output logic [twsc_pkg::RspDataW-1:0]         rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [twsc_pkg::CsrAddrW-1:0]    csr_addr,
   input  wire logic [twsc_pkg::CsrDataW-1:0]    csr_wdata
);

   twsc_pkg::cmd_type cmd;

   twsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   twsc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> cmd.op == twsc_pkg::OP_ERR && !cmd.wheel)
      else $error("sequencer did not start after an accepted word");

   a_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> cmd.op == twsc_pkg::OP_NONE || cmd.op == twsc_pkg::OP_LOAD)
      else $error("datapath busy while input is ready");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == twsc_pkg::OP_OUT |-> !rsp_tvalid || rsp_tready)
      else $error("result register overwritten while held");

   a_rev_right: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9:0] != 10'd0)
      else $error("right wheel reversed with zero duty");

   a_rev_left: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tdata[20:11] != 10'd0)
      else $error("left wheel reversed with zero duty");

endmodule
`default_nettype wire

// ===== sim/twsc_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Speed controller scoreboard
// Predicts the duty word of each control tick for both wheels from the
// register settings and the integrator and windup state, and checks every
// duty word that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
package twsc_tb_pkg;
   import twsc_pkg::*;

   typedef struct packed {
      logic [AdcW-1:0]   adc_left;
      logic [AdcW-1:0]   adc_right;
      logic [SpeedW-1:0] meas_left;
      logic [SpeedW-1:0] meas_right;
      logic [SpeedW-1:0] ref_left;
      logic [SpeedW-1:0] ref_right;
   } tick_word_t;

   typedef struct packed {
      logic [1:0]       fill;
      logic             reverse_left;
      logic [DutyW-1:0] duty_left;
      logic             reverse_right;
      logic [DutyW-1:0] duty_right;
   } duty_word_t;

   localparam longint INT32_HI = 64'sd2147483647;
   localparam longint INT32_LO = -64'sd2147483648;

   class speed_ctrl_scoreboard;
      longint     integral_gain;
      longint     speed_gain;
      longint     current_gain;
      longint     integral_limit;
      longint     zero_current_code;
      int         integrator [2];
      int         excess [2];
      duty_word_t expected_duty [$];
      int unsigned errors;

      function new();
         integral_gain     = INTEGRAL_GAIN_RST;
         speed_gain        = SPEED_GAIN_RST;
         current_gain      = CURRENT_GAIN_RST;
         integral_limit    = INTEGRAL_LIMIT_RST;
         zero_current_code = ZERO_CURRENT_RST;
         integrator        = '{0, 0};
         excess            = '{0, 0};
         errors            = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CsrDataW-1:0] value);
         logic signed [GainW-1:0] gain;
         gain = value[GainW-1:0];
         case (idx)
            CSR_INTEGRAL_GAIN:  integral_gain = gain;
            CSR_SPEED_GAIN:     speed_gain = gain;
            CSR_CURRENT_GAIN:   current_gain = gain;
            CSR_INTEGRAL_LIMIT: integral_limit = value[LimitW-1:0];
            CSR_ZERO_CURRENT:   zero_current_code = value[AdcW-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_duty.size();
      endfunction

      // One wheel: integrator update with anti-windup, clamp, gain sum, duty shaping.
      function void wheel_duty(int w, logic signed [SpeedW-1:0] ref_speed,
                               logic signed [SpeedW-1:0] meas_speed,
                               logic [AdcW-1:0] adc,
                               output logic [DutyW-1:0] duty, output logic reverse);
         longint meas;
         longint current;
         longint err;
         longint x;
         longint clamped;
         longint over;
         longint sum;
         longint v;
         bit     zero_ref;
         meas     = meas_speed;
         zero_ref = (ref_speed == 0);
         current  = adc;
         current  = 17 * (current - zero_current_code);
         err      = ref_speed;
         err      = err - meas - 10 * longint'(excess[w]);
         if (zero_ref) begin
            x = 0;
         end else begin
            x = (longint'(integrator[w]) * 32 + ((210 * err) >>> 15)) >>> 5;
            if (x > INT32_HI) x = INT32_HI;
            if (x < INT32_LO) x = INT32_LO;
         end
         integrator[w] = int'(x);
         if (x >= integral_limit) begin
            clamped = integral_limit;
            over    = x - integral_limit;
         end else if (x <= -integral_limit) begin
            clamped = -integral_limit;
            over    = x + integral_limit;
         end else begin
            clamped = x;
            over    = 0;
         end
         excess[w] = int'(over);
         sum = -((integral_gain * clamped) >>> 11) - ((speed_gain * meas) >>> 11)
               - ((current_gain * current) >>> 11);
         if (zero_ref) begin
            v = 0;
         end else begin
            v = (73 * sum) >>> 12;
         end
         reverse = (v < 0);
         if (v < 0) v = -v;
         if (v > 64'sd1023) v = 64'sd1023;
         duty = v[DutyW-1:0];
      endfunction

      function void note_tick(tick_word_t t);
         duty_word_t d;
         logic [DutyW-1:0] duty;
         logic reverse;
         d = '0;
         wheel_duty(0, t.ref_right, t.meas_right, t.adc_right, duty, reverse);
         d.duty_right    = duty;
         d.reverse_right = reverse;
         wheel_duty(1, t.ref_left, t.meas_left, t.adc_left, duty, reverse);
         d.duty_left    = duty;
         d.reverse_left = reverse;
         expected_duty.push_back(d);
      endfunction

      function void compare_field(string field, logic [DutyW-1:0] want,
                                  logic [DutyW-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_duty(duty_word_t got);
         duty_word_t want;
         if (expected_duty.size() == 0) begin
            $display("%0t: duty word %h with none expected", $time, got);
            errors++;
            return;
         end
         want = expected_duty.pop_front();
         compare_field("duty_right", want.duty_right, got.duty_right);
         compare_field("reverse_right", {9'd0, want.reverse_right}, {9'd0, got.reverse_right});
         compare_field("duty_left", want.duty_left, got.duty_left);
         compare_field("reverse_left", {9'd0, want.reverse_left}, {9'd0, got.reverse_left});
      endfunction
   endclass

endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-wheel speed controller testbench
// Drives control ticks through the request stream under several register
// settings, with random idle bursts on both sides and a long output stall,
// and checks every duty word against a scoreboard prediction.
// ----------------------------------------------------------------------------
module testbench;
   import twsc_pkg::*;
   import twsc_tb_pkg::*;

   localparam int RANDOM_TICKS = 1750;
   localparam int PHASES       = 7;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic [SpeedW-1:0] SPEED_HI = {1'b0, {(SpeedW-1){1'b1}}};
   localparam logic [SpeedW-1:0] SPEED_LO = {1'b1, {(SpeedW-1){1'b0}}};
   localparam logic [AdcW-1:0]   ADC_HI   = '1;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   speed_ctrl_scoreboard duty_board;
   bit                   req_gaps = 1'b0;
   bit                   rsp_gaps = 1'b0;
   int unsigned          hold_requests = 0;
   int unsigned          holds_served = 0;
   int unsigned          rsp_idle_left = 0;
   int unsigned          cycle_count = 0;
   logic [SpeedW-1:0]    held_ref [2];
   logic [AdcW-1:0]      adc_center = ZERO_CURRENT_RST;

   two_wheel_state_feedback_speed_ctrl_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("two_wheel_state_feedback_speed_ctrl_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) duty_board.check_duty(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_idle_left = 0;
      end else begin
         if (holds_served != hold_requests) begin
            rsp_idle_left = LONG_HOLD;
            holds_served++;
         end else if (rsp_idle_left == 0 && rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_idle_left = $urandom_range(1, 7);
         end
         if (rsp_idle_left != 0) begin
            rsp_tready <= 1'b0;
            rsp_idle_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_tick(input tick_word_t t);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
      duty_board.note_tick(t);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (duty_board.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      duty_board.write_reg(idx, value);
   endtask

   task automatic apply_settings(input logic [GainW-1:0] ki, input logic [GainW-1:0] ks,
                                 input logic [GainW-1:0] kc,
                                 input logic [LimitW-1:0] limit,
                                 input logic [AdcW-1:0] offset);
      wait_idle();
      write_reg(CSR_INTEGRAL_GAIN, {7'd0, ki});
      write_reg(CSR_SPEED_GAIN, {7'd0, ks});
      write_reg(CSR_CURRENT_GAIN, {7'd0, kc});
      write_reg(CSR_INTEGRAL_LIMIT, limit);
      write_reg(CSR_ZERO_CURRENT, {11'd0, offset});
      csr_we     <= 1'b0;
      adc_center = offset;
   endtask

   function automatic tick_word_t tick(logic [SpeedW-1:0] rr, logic [SpeedW-1:0] rl,
                                       logic [SpeedW-1:0] mr, logic [SpeedW-1:0] ml,
                                       logic [AdcW-1:0] ar, logic [AdcW-1:0] al);
      tick_word_t t;
      t.ref_right  = rr;
      t.ref_left   = rl;
      t.meas_right = mr;
      t.meas_left  = ml;
      t.adc_right  = ar;
      t.adc_left   = al;
      return t;
   endfunction

   function automatic tick_word_t directed_tick(int k);
      case (k)
         0:  return tick('0, '0, '0, '0, '0, '0);
         1:  return tick('0, '0, SPEED_HI, SPEED_LO, ADC_HI, '0);
         2:  return tick(SPEED_HI, SPEED_LO, SPEED_LO, SPEED_HI, '0, ADC_HI);
         8:  return tick(SPEED_LO, SPEED_LO, SPEED_HI, SPEED_HI, '0, '0);
         9:  return tick(SpeedW'(1), '1, '0, '0, AdcW'(2048), AdcW'(2048));
         10: return tick(SPEED_LO, SPEED_HI, SPEED_HI, SPEED_LO, '0, '0);
         11: return tick('0, SPEED_HI, '0, SPEED_LO, AdcW'(17), AdcW'(4000));
         12: return tick(SpeedW'(100), SpeedW'(-100), SpeedW'(100), SpeedW'(-100),
                         AdcW'(1), ADC_HI);
         13: return tick(SPEED_HI, SPEED_HI, '0, '0, '0, '0);
         14: return tick(SPEED_LO, SPEED_LO, SPEED_LO, SPEED_LO, ADC_HI, ADC_HI);
         15: return tick(SPEED_HI, SPEED_LO, SPEED_HI, SPEED_LO, AdcW'(2048), AdcW'(1));
         default: return tick(SPEED_HI, SPEED_HI, SPEED_LO, SPEED_LO, ADC_HI, ADC_HI);
      endcase
   endfunction

   function automatic logic [SpeedW-1:0] random_speed();
      logic [SpeedW-1:0] s;
      case ($urandom_range(0, 5))
         0: s = ($urandom_range(0, 1) == 0) ? SPEED_HI : SPEED_LO;
         1: s = SpeedW'(int'($urandom_range(0, 4095)) - 2048);
         2: s = SpeedW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         default: s = SpeedW'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [SpeedW-1:0] near_speed(logic [SpeedW-1:0] center);
      int unsigned span;
      span = (1 << $urandom_range(1, 20)) - 1;
      return center + SpeedW'($urandom_range(0, span)) - SpeedW'(span >> 1);
   endfunction

   function automatic logic [AdcW-1:0] random_adc();
      logic [AdcW-1:0] a;
      case ($urandom_range(0, 3))
         0: a = '0;
         1: a = ADC_HI;
         default: a = AdcW'($urandom);
      endcase
      return a;
   endfunction

   // Mostly steady references with measurements close to them and currents close
   // to the zero-current code, some zero references and some words with unrelated field values.
   function automatic tick_word_t random_tick();
      tick_word_t  t;
      int unsigned mode;
      logic [127:0] bits;
      mode = $urandom_range(0, 9);
      for (int w = 0; w < 2; w++) begin
         if ($urandom_range(0, 24) == 0)
            held_ref[w] = ($urandom_range(0, 3) == 0) ? '0 : random_speed();
      end
      if (mode < 7) begin
         t.ref_right  = held_ref[0];
         t.ref_left   = held_ref[1];
         t.meas_right = near_speed(held_ref[0]);
         t.meas_left  = near_speed(held_ref[1]);
         t.adc_right  = adc_center + AdcW'($urandom_range(0, 63)) - AdcW'(32);
         t.adc_left   = adc_center + AdcW'($urandom_range(0, 63)) - AdcW'(32);
      end else if (mode == 7) begin
         bits = {$urandom, $urandom, $urandom, $urandom};
         t = bits[ReqDataW-1:0];
         if ($urandom_range(0, 2) != 0) t.ref_right = '0;
         if ($urandom_range(0, 2) != 0) t.ref_left = '0;
      end else begin
         t.ref_right  = random_speed();
         t.ref_left   = random_speed();
         t.meas_right = random_speed();
         t.meas_left  = random_speed();
         t.adc_right  = random_adc();
         t.adc_left   = random_adc();
      end
      return t;
   endfunction

   initial begin
      duty_board  = new();
      held_ref[0] = '0;
      held_ref[1] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      rsp_gaps = 1'b1;
      for (int k = 0; k < 16; k++) send_tick(directed_tick(k));
      apply_settings(INTEGRAL_GAIN_RST, SPEED_GAIN_RST, CURRENT_GAIN_RST, '0, AdcW'(2048));
      for (int k = 2; k < 10; k++) send_tick(directed_tick(k));

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_settings(16'h8000, 16'h8000, 16'h8000, 23'd1, '0);
            1: apply_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 23'h7FFFFF, ADC_HI);
            2: apply_settings(INTEGRAL_GAIN_RST, SPEED_GAIN_RST, CURRENT_GAIN_RST,
                              INTEGRAL_LIMIT_RST, ZERO_CURRENT_RST);
            3: apply_settings(GainW'($urandom), GainW'($urandom), GainW'($urandom), '0,
                              AdcW'($urandom));
            default: apply_settings(GainW'($urandom), GainW'($urandom), GainW'($urandom),
                                    LimitW'($urandom_range(1, 1 << 18)), AdcW'($urandom));
         endcase
         req_gaps = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_gaps = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         if (p == 1) begin
            req_gaps = 1'b0;
            hold_requests++;
         end
         for (int n = 0; n < RANDOM_TICKS / PHASES; n++) send_tick(random_tick());
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (duty_board.errors == 0) begin
         $display("two_wheel_state_feedback_speed_ctrl_top: match");
      end else begin
         $display("two_wheel_state_feedback_speed_ctrl_top: mismatch");
      end
      $finish;
   end

endmodule
